[hw/rtl/bpc_pkg.sv]
//------------------------------------------------------------------------------
// bpc_pkg
// Types and constants shared by the barometric compensation pipeline.
//------------------------------------------------------------------------------
package bpc_pkg;

   typedef struct packed {
      logic [15:0] raw_temperature;
      logic [23:0] raw_pressure_bytes;
   } req_type;

   typedef struct packed {
      logic signed [15:0] temperature_decidegrees;
      logic [17:0]        pressure_pa;
      logic               divide_error;
   } rsp_type;

   localparam logic [1:0] CSR_COEF_A = 2'd0;
   localparam logic [1:0] CSR_COEF_B = 2'd1;
   localparam logic [1:0] CSR_COEF_C = 2'd2;
   localparam logic [1:0] CSR_OSS    = 2'd3;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   localparam int B6_OFFSET = 4000;
   localparam int P_ROUND   = 3791;
   localparam int P_C1      = 3038;
   localparam int P_C2      = -7357;
   localparam int P_MAX     = 262143;
   localparam int T_MIN     = -32768;
   localparam int T_MAX     = 32767;

endpackage

[hw/rtl/bpc_divider.sv]
//------------------------------------------------------------------------------
// bpc_divider
// Pipelined restoring divider, one quotient bit per stage. Unsigned
// operands; a tag travels alongside each transfer.
//------------------------------------------------------------------------------
module bpc_divider #(
   parameter int N_W   = 32,
   parameter int D_W   = 32,
   parameter int TAG_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [N_W-1:0]   in_num,
   input  logic [D_W-1:0]   in_den,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [N_W-1:0]   out_quo,
   output logic [TAG_W-1:0] out_tag
);

   logic             vld_ff [N_W+1];
   logic [N_W-1:0]   num_ff [N_W+1];
   logic [D_W:0]     rem_ff [N_W+1];
   logic [D_W-1:0]   den_ff [N_W+1];
   logic [TAG_W-1:0] tag_ff [N_W+1];

   always_comb begin
      vld_ff[0] = in_valid;
      num_ff[0] = in_num;
      rem_ff[0] = '0;
      den_ff[0] = in_den;
      tag_ff[0] = in_tag;
   end

   // one quotient bit per stage, numerator shifts in from the top
   for (genvar s = 0; s < N_W; s++) begin : g_stage
      logic [D_W+1:0] trial;
      logic [D_W+1:0] shifted;
      logic [D_W:0]   rem_in;
      always_comb begin
         shifted = {rem_ff[s], num_ff[s][N_W-1]};
         trial   = shifted - {2'b00, den_ff[s]};
         rem_in  = trial[D_W+1] ? shifted[D_W:0] : trial[D_W:0];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else begin
            vld_ff[s+1] <= vld_ff[s];
         end
         num_ff[s+1] <= {num_ff[s][N_W-2:0], ~trial[D_W+1]};
         rem_ff[s+1] <= rem_in;
         den_ff[s+1] <= den_ff[s];
         tag_ff[s+1] <= tag_ff[s];
      end
   end

   assign out_valid = vld_ff[N_W];
   assign out_quo   = num_ff[N_W];
   assign out_tag   = tag_ff[N_W];

endmodule

[hw/rtl/barometric_pressure_compensation.sv]
//------------------------------------------------------------------------------
// barometric_pressure_compensation
// Integer compensation of raw barometer temperature and pressure readings.
//
// Usage: pulse req_start with req_data for one cycle per reading pair; the
// block never asserts req_busy, so one pair may enter every clock. Each pair
// gives one result on rsp_data marked by rsp_strobe for exactly one cycle.
// The receiver cannot stall. The datapath is a 28-stage temperature
// divider, a 32-stage pressure divider and ten register stages around
// them. Throughput is one pair per cycle. Calibration words and
// oversampling come through the csr_ write port and may change only
// while the pipeline is empty. Reset clears the valid bits and sets the
// calibration registers to zero, oversampling to 1.
//------------------------------------------------------------------------------
module barometric_pressure_compensation (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_start,
   output logic                   req_busy,
   input  bpc_pkg::req_type       req_data,
   output logic                   rsp_strobe,
   output bpc_pkg::rsp_type       rsp_data,
   input  logic                   csr_we,
   input  logic [bpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bpc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int TD_W = 28;   // |MC*2048| < 2^27
   localparam int PD_W = 32;

   // configuration
   logic [63:0] coef_a_ff, coef_b_ff;
   logic [47:0] coef_c_ff;
   logic [1:0]  oss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff <= '0;
         coef_b_ff <= '0;
         coef_c_ff <= '0;
         oss_ff    <= 2'd1;
      end else if (csr_we) begin
         case (csr_index)
            bpc_pkg::CSR_COEF_A: coef_a_ff <= csr_wdata;
            bpc_pkg::CSR_COEF_B: coef_b_ff <= csr_wdata;
            bpc_pkg::CSR_COEF_C: coef_c_ff <= csr_wdata[47:0];
            bpc_pkg::CSR_OSS:    oss_ff    <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   logic signed [17:0] ac1, ac2, ac3, b1, b2, mc, md;
   logic signed [17:0] ac4, ac5, ac6;
   assign ac1 = 18'(signed'(coef_a_ff[63:48]));
   assign ac2 = 18'(signed'(coef_a_ff[47:32]));
   assign ac3 = 18'(signed'(coef_a_ff[31:16]));
   assign ac4 = signed'({2'b00, coef_a_ff[15:0]});
   assign ac5 = signed'({2'b00, coef_b_ff[63:48]});
   assign ac6 = signed'({2'b00, coef_b_ff[47:32]});
   assign b1  = 18'(signed'(coef_b_ff[31:16]));
   assign b2  = 18'(signed'(coef_b_ff[15:0]));
   assign mc  = 18'(signed'(coef_c_ff[31:16]));
   assign md  = 18'(signed'(coef_c_ff[15:0]));

   assign req_busy = 1'b0;
   logic accept;
   assign accept = req_start & ~req_busy;

   // stage 1: UT - AC6, UP
   logic        s1_vld_ff;
   logic signed [17:0] s1_d_ff;
   logic [23:0] s1_up_ff;
   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else       s1_vld_ff <= accept;
      s1_d_ff  <= signed'({2'b00, req_data.raw_temperature}) - ac6;
      s1_up_ff <= req_data.raw_pressure_bytes >> (4'd8 - {2'b00, oss_ff});
   end

   // stage 2: X1 = (UT-AC6)*AC5 >> 15, den = X1 + MD
   logic        s2_vld_ff;
   logic signed [19:0] s2_x1_ff;
   logic signed [20:0] s2_den_ff;
   logic [23:0] s2_up_ff;
   logic signed [35:0] s2_prod;
   logic signed [19:0] s2_x1;
   assign s2_prod = s1_d_ff * ac5;
   assign s2_x1   = 20'(s2_prod >>> 15);
   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else       s2_vld_ff <= s1_vld_ff;
      s2_x1_ff  <= s2_x1;
      s2_den_ff <= 21'(s2_x1) + 21'(md);
      s2_up_ff  <= s1_up_ff;
   end

   // stage 3: sign-magnitude for the temperature divide
   logic signed [TD_W-1:0] s3_num;
   assign s3_num = TD_W'(mc) <<< 11;
   logic [TD_W-1:0] td_num;
   logic [20:0]     td_den;
   logic            td_neg;
   assign td_num = s3_num[TD_W-1] ? TD_W'(-s3_num) : s3_num;
   assign td_den = s2_den_ff[20] ? 21'(-s2_den_ff) : s2_den_ff;
   assign td_neg = s3_num[TD_W-1] ^ s2_den_ff[20];

   localparam int TTAG_W = 20 + 24 + 2;
   logic              td_vld;
   logic [TD_W-1:0]   td_quo;
   logic [TTAG_W-1:0] td_tag;
   bpc_divider #(.N_W(TD_W), .D_W(21), .TAG_W(TTAG_W)) u_tdiv (
      .clock(clock), .reset(reset), .in_valid(s2_vld_ff),
      .in_num(td_num), .in_den(td_den),
      .in_tag({s2_x1_ff, s2_up_ff, td_neg, (s2_den_ff == '0)}),
      .out_valid(td_vld), .out_quo(td_quo), .out_tag(td_tag));

   // stage 4: B5, T, B6
   logic signed [19:0] t_x1;
   logic [23:0]        t_up;
   logic               t_neg, t_err;
   assign {t_x1, t_up, t_neg, t_err} = td_tag;
   logic signed [TD_W:0] t_x2, t_b5;
   assign t_x2 = t_neg ? -signed'({1'b0, td_quo}) : signed'({1'b0, td_quo});
   assign t_b5 = t_x2 + (TD_W+1)'(t_x1);

   logic        s4_vld_ff, s4_err_ff;
   logic signed [TD_W:0] s4_b6_ff;
   logic signed [15:0] s4_t_ff;
   logic [23:0] s4_up_ff;
   logic signed [TD_W:0] t_raw;
   assign t_raw = (t_b5 + (TD_W+1)'(8)) >>> 4;
   always_ff @(posedge clock) begin
      if (reset) s4_vld_ff <= 1'b0;
      else       s4_vld_ff <= td_vld;
      s4_err_ff <= t_err;
      s4_up_ff  <= t_up;
      s4_b6_ff  <= t_b5 - (TD_W+1)'(bpc_pkg::B6_OFFSET);
      if (t_raw < bpc_pkg::T_MIN)      s4_t_ff <= 16'(bpc_pkg::T_MIN);
      else if (t_raw > bpc_pkg::T_MAX) s4_t_ff <= 16'(bpc_pkg::T_MAX);
      else                             s4_t_ff <= 16'(t_raw);
   end

   // stage 5: SQ = B6^2 >> 12, AC2*B6, AC3*B6
   logic        s5_vld_ff, s5_err_ff;
   logic signed [15:0] s5_t_ff;
   logic [23:0] s5_up_ff;
   logic signed [45:0] s5_sq_ff;
   logic signed [47:0] s5_a2_ff, s5_a3_ff;
   logic signed [57:0] b6sq;
   assign b6sq = s4_b6_ff * s4_b6_ff;
   always_ff @(posedge clock) begin
      if (reset) s5_vld_ff <= 1'b0;
      else       s5_vld_ff <= s4_vld_ff;
      s5_err_ff <= s4_err_ff;
      s5_t_ff   <= s4_t_ff;
      s5_up_ff  <= s4_up_ff;
      s5_sq_ff  <= 46'(b6sq >>> 12);
      s5_a2_ff  <= 48'(s4_b6_ff * ac2);
      s5_a3_ff  <= 48'(s4_b6_ff * ac3);
   end

   // stage 6: B2*SQ, B1*SQ
   logic        s6_vld_ff, s6_err_ff;
   logic signed [15:0] s6_t_ff;
   logic [23:0] s6_up_ff;
   logic signed [63:0] s6_b2_ff, s6_b1_ff;
   logic signed [47:0] s6_a2_ff, s6_a3_ff;
   always_ff @(posedge clock) begin
      if (reset) s6_vld_ff <= 1'b0;
      else       s6_vld_ff <= s5_vld_ff;
      s6_err_ff <= s5_err_ff;
      s6_t_ff   <= s5_t_ff;
      s6_up_ff  <= s5_up_ff;
      s6_b2_ff  <= 64'(s5_sq_ff * b2);
      s6_b1_ff  <= 64'(s5_sq_ff * b1);
      s6_a2_ff  <= s5_a2_ff;
      s6_a3_ff  <= s5_a3_ff;
   end

   // stage 7: B3 and X3 for B4
   logic signed [63:0] x3a, b3pre, x3b;
   logic signed [63:0] b3;
   assign x3a   = (s6_b2_ff >>> 11) + 64'(s6_a2_ff >>> 11);
   assign b3pre = (((64'(ac1) <<< 2) + x3a) <<< oss_ff) + 64'sd2;
   assign b3    = b3pre[63] ? -((-b3pre) >>> 2) : (b3pre >>> 2);
   assign x3b   = (64'(s6_a3_ff >>> 13) + (s6_b1_ff >>> 16) + 64'sd2) >>> 2;
   logic        s7_vld_ff, s7_err_ff;
   logic signed [15:0] s7_t_ff;
   logic [31:0] s7_diff_ff, s7_x3_ff;
   always_ff @(posedge clock) begin
      if (reset) s7_vld_ff <= 1'b0;
      else       s7_vld_ff <= s6_vld_ff;
      s7_err_ff  <= s6_err_ff;
      s7_t_ff    <= s6_t_ff;
      s7_diff_ff <= {8'h00, s6_up_ff} - b3[31:0];
      s7_x3_ff   <= x3b[31:0] + 32'd32768;
   end

   // stage 8: B4 and B7 products
   logic        s8_vld_ff, s8_err_ff;
   logic signed [15:0] s8_t_ff;
   logic [31:0] s8_b4_ff, s8_b7_ff;
   logic [47:0] b4p;
   assign b4p = s7_x3_ff * ac4[15:0];
   always_ff @(posedge clock) begin
      if (reset) s8_vld_ff <= 1'b0;
      else       s8_vld_ff <= s7_vld_ff;
      s8_err_ff <= s7_err_ff;
      s8_t_ff   <= s7_t_ff;
      s8_b4_ff  <= {15'd0, b4p[31:15]};
      s8_b7_ff  <= 32'(s7_diff_ff * (32'd50000 >> oss_ff));
   end

   // pressure divide; large B7 divides first and doubles afterwards
   logic pd_big, p_err;
   assign pd_big = s8_b7_ff[31];
   assign p_err  = s8_err_ff | (s8_b4_ff == '0);
   localparam int PTAG_W = 16 + 2;
   logic              pd_vld;
   logic [PD_W-1:0]   pd_quo;
   logic [PTAG_W-1:0] pd_tag;
   bpc_divider #(.N_W(PD_W), .D_W(32), .TAG_W(PTAG_W)) u_pdiv (
      .clock(clock), .reset(reset), .in_valid(s8_vld_ff),
      .in_num(pd_big ? s8_b7_ff : {s8_b7_ff[30:0], 1'b0}),
      .in_den(s8_b4_ff), .in_tag({s8_t_ff, pd_big, p_err}),
      .out_valid(pd_vld), .out_quo(pd_quo), .out_tag(pd_tag));

   logic signed [15:0] p_t;
   logic p_big, p_e;
   assign {p_t, p_big, p_e} = pd_tag;
   logic [31:0] pq;
   assign pq = p_big ? {pd_quo[30:0], 1'b0} : pd_quo;

   // stage 9: correction products
   logic        s9_vld_ff, s9_err_ff;
   logic signed [15:0] s9_t_ff;
   logic [31:0] s9_p_ff;
   logic [47:0] s9_sq_ff;
   logic signed [50:0] s9_m2_ff;
   always_ff @(posedge clock) begin
      if (reset) s9_vld_ff <= 1'b0;
      else       s9_vld_ff <= pd_vld;
      s9_err_ff <= p_e;
      s9_t_ff   <= p_t;
      s9_p_ff   <= pq;
      s9_sq_ff  <= pq[31:8] * pq[31:8];
      s9_m2_ff  <= signed'({19'd0, pq}) * 51'(bpc_pkg::P_C2);
   end

   // stage 10: *3038
   logic        s10_vld_ff, s10_err_ff;
   logic signed [15:0] s10_t_ff;
   logic [31:0] s10_p_ff;
   logic signed [63:0] s10_x1_ff, s10_x2_ff;
   always_ff @(posedge clock) begin
      if (reset) s10_vld_ff <= 1'b0;
      else       s10_vld_ff <= s9_vld_ff;
      s10_err_ff <= s9_err_ff;
      s10_t_ff   <= s9_t_ff;
      s10_p_ff   <= s9_p_ff;
      s10_x1_ff  <= signed'({4'd0, s9_sq_ff, 12'd0} >> 12) * 64'(bpc_pkg::P_C1) >>> 16;
      s10_x2_ff  <= 64'(s9_m2_ff >>> 16);
   end

   // stage 11: final sum and saturation
   logic signed [63:0] pf;
   assign pf = signed'({32'd0, s10_p_ff})
             + ((s10_x1_ff + s10_x2_ff + 64'(bpc_pkg::P_ROUND)) >>> 4);
   logic   out_vld_ff;
   bpc_pkg::rsp_type out_ff;
   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else       out_vld_ff <= s10_vld_ff;
      if (s10_err_ff) begin
         out_ff <= '{temperature_decidegrees: '0, pressure_pa: '0, divide_error: 1'b1};
      end else begin
         out_ff.temperature_decidegrees <= s10_t_ff;
         out_ff.divide_error            <= 1'b0;
         if (pf < 0)                  out_ff.pressure_pa <= '0;
         else if (pf > bpc_pkg::P_MAX) out_ff.pressure_pa <= 18'(bpc_pkg::P_MAX);
         else                          out_ff.pressure_pa <= pf[17:0];
      end
   end

   assign rsp_strobe = out_vld_ff;
   assign rsp_data   = out_ff;

   // checks
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.divide_error |->
         rsp_data.pressure_pa == '0 && rsp_data.temperature_decidegrees == '0)
      else $error("error result carries nonzero fields");
   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      s10_vld_ff |=> rsp_strobe)
      else $error("result lost in last stage");
   a_no_busy: assert property (@(posedge clock) !req_busy)
      else $error("busy raised");

endmodule
